// File: rtl/gn3d_pkg.sv
`timescale 1ns / 1ps
// gn3d_pkg: shared types, constants and fixed-point helpers for gradient_noise_3d.
// No dependencies.
package gn3d_pkg;

    // Fixed-point format and table geometry
    localparam int FRACTION_BITS = 16;
    localparam int TABLE_ENTRIES = 256;
    localparam int IW            = $clog2(TABLE_ENTRIES);   // table address width
    localparam int QW            = FRACTION_BITS + 8;       // internal signed Q width
    localparam int COORD_W       = 24;
    localparam int BYTE_W        = 8;
    localparam int OUT_W         = 17;
    localparam int Q_DEPTH       = 2;
    localparam int QPW           = $clog2(Q_DEPTH);

    localparam logic signed [QW-1:0] ONE_Q     = QW'(64'sd1 <<< FRACTION_BITS);
    localparam logic signed [QW-1:0] TEN_Q     = QW'(64'sd10 <<< FRACTION_BITS);
    localparam logic signed [QW-1:0] FIFTEEN_Q = QW'(64'sd15 <<< FRACTION_BITS);
    localparam logic [2*QW-1:0]      HALF_P    = (2*QW)'(64'd1 << (FRACTION_BITS - 1));
    localparam logic [OUT_W-1:0]     OUT_MAX   = OUT_W'(65536);

    // Request kinds
    typedef enum logic [0:0] {
        OP_EVAL  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    // One request as it moves from front to back
    typedef struct packed {
        op_t                op;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_z;
        logic [BYTE_W-1:0]  table_index;
        logic [BYTE_W-1:0]  table_value;
    } req_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic valid;
    } q_stat_t;

    // Signed fixed-point product, rounded half away from zero
    function automatic logic signed [QW-1:0] mulq(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
        logic            neg;
        logic [QW-1:0]   ma;
        logic [QW-1:0]   mb;
        logic [2*QW-1:0] prod;
        logic [2*QW-1:0] r;
        logic [QW-1:0]   rt;
        neg  = a[QW-1] ^ b[QW-1];
        ma   = a[QW-1] ? (QW'(0) - $unsigned(a)) : $unsigned(a);
        mb   = b[QW-1] ? (QW'(0) - $unsigned(b)) : $unsigned(b);
        prod = (2*QW)'(ma) * (2*QW)'(mb);
        r    = (prod + HALF_P) >> FRACTION_BITS;
        rt   = r[QW-1:0];
        return signed'(neg ? (QW'(0) - rt) : rt);
    endfunction

    // a + t * (b - a)
    function automatic logic signed [QW-1:0] lerp(input logic signed [QW-1:0] t,
                                                  input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
        logic signed [QW-1:0] d;
        d = b - a;
        return a + mulq(t, d);
    endfunction

    // Gradient dot product picked by the low four hash bits
    function automatic logic signed [QW-1:0] grad(input logic [BYTE_W-1:0] hash,
                                                  input logic signed [QW-1:0] x,
                                                  input logic signed [QW-1:0] y,
                                                  input logic signed [QW-1:0] z);
        logic [3:0]           h;
        logic signed [QW-1:0] u;
        logic signed [QW-1:0] v;
        logic signed [QW-1:0] su;
        logic signed [QW-1:0] sv;
        h  = hash[3:0];
        u  = (h < 4'd8) ? x : y;
        v  = (h < 4'd4) ? y : (((h == 4'd12) || (h == 4'd14)) ? x : z);
        su = h[0] ? -u : u;
        sv = h[1] ? -v : v;
        return su + sv;
    endfunction

endpackage

// File: rtl/gn3d_ram.sv
`timescale 1ns / 1ps
// gn3d_ram: generic RAM, one write port and two registered read ports.
// No dependencies.
module gn3d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered reads
    always_ff @(posedge clk)
    begin
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// File: rtl/gn3d_front.sv
`timescale 1ns / 1ps
// gn3d_front: accepts requests, tags them as evaluate or table write, feeds the queue.
// Depends on gn3d_pkg.
module gn3d_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           operation,
    input  logic [gn3d_pkg::COORD_W-1:0]   coord_x,
    input  logic [gn3d_pkg::COORD_W-1:0]   coord_y,
    input  logic [gn3d_pkg::COORD_W-1:0]   coord_z,
    input  logic [gn3d_pkg::BYTE_W-1:0]    table_index,
    input  logic [gn3d_pkg::BYTE_W-1:0]    table_value,
    input  gn3d_pkg::q_stat_t              q_stat,
    output logic                           busy,
    output logic                           push,
    output gn3d_pkg::req_t                 push_req
);

    logic           valid_reg;
    logic           valid_next;
    gn3d_pkg::req_t req_reg;
    logic           accept;

    // hold a request only while the queue is full
    assign busy   = valid_reg && q_stat.full;
    assign push   = valid_reg && !q_stat.full;
    assign accept = start && !busy;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // classify and capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.op          <= operation ? gn3d_pkg::OP_WRITE : gn3d_pkg::OP_EVAL;
            req_reg.coord_x     <= coord_x;
            req_reg.coord_y     <= coord_y;
            req_reg.coord_z     <= coord_z;
            req_reg.table_index <= table_index;
            req_reg.table_value <= table_value;
        end
    end

    assign push_req = req_reg;

endmodule

// File: rtl/gn3d_queue.sv
`timescale 1ns / 1ps
// gn3d_queue: short request queue between front and back; back drains it every cycle.
// Depends on gn3d_pkg.
module gn3d_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  gn3d_pkg::req_t     push_req,
    output gn3d_pkg::q_stat_t  q_stat,
    output gn3d_pkg::req_t     head
);

    gn3d_pkg::req_t                q_mem_reg [gn3d_pkg::Q_DEPTH];
    logic [gn3d_pkg::QPW-1:0]      wr_ptr_reg;
    logic [gn3d_pkg::QPW-1:0]      rd_ptr_reg;
    logic [gn3d_pkg::QPW:0]        count_reg;
    logic [gn3d_pkg::QPW:0]        count_next;
    logic                          do_push;
    logic                          do_pop;

    assign q_stat.full  = (count_reg == (gn3d_pkg::QPW+1)'(gn3d_pkg::Q_DEPTH));
    assign q_stat.valid = (count_reg != '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = q_stat.valid;
    assign head         = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (gn3d_pkg::QPW+1)'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - (gn3d_pkg::QPW+1)'(1);
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + gn3d_pkg::QPW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + gn3d_pkg::QPW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// File: rtl/gn3d_back.sv
`timescale 1ns / 1ps
// gn3d_back: noise pipeline: three hash levels through table copies, fade, lerp, scale.
// Depends on gn3d_pkg and gn3d_ram.
module gn3d_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  gn3d_pkg::req_t                in_req,
    output logic                          done,
    output logic [gn3d_pkg::OUT_W-1:0]    noise_value
);

    localparam int FB = gn3d_pkg::FRACTION_BITS;
    localparam int IW = gn3d_pkg::IW;
    localparam int QW = gn3d_pkg::QW;
    localparam int BW = gn3d_pkg::BYTE_W;
    localparam int SW = QW + 17;

    // ---------------- stage 0: level-1 table reads ----------------
    logic [IW-1:0] x0;
    logic [IW-1:0] wr_addr0;
    logic          wr0;
    logic [BW-1:0] l1_a;
    logic [BW-1:0] l1_b;

    assign x0       = IW'(in_req.coord_x >> FB);
    assign wr_addr0 = IW'(in_req.table_index);
    assign wr0      = in_valid && (in_req.op == gn3d_pkg::OP_WRITE);

    gn3d_ram #(.WIDTH(BW), .DEPTH(gn3d_pkg::TABLE_ENTRIES)) u_ram_l1 (
        .clk(clk), .we(wr0), .waddr(wr_addr0), .wdata(in_req.table_value),
        .raddr_a(x0), .raddr_b(x0 + IW'(1)), .rdata_a(l1_a), .rdata_b(l1_b)
    );

    logic                s1_valid_reg;
    gn3d_pkg::op_t       s1_op_reg;
    logic [IW-1:0]       s1_index_reg;
    logic [BW-1:0]       s1_value_reg;
    logic [FB-1:0]       s1_frac_reg [3];
    logic [IW-1:0]       s1_y_reg;
    logic [IW-1:0]       s1_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg      <= in_req.op;
        s1_index_reg   <= wr_addr0;
        s1_value_reg   <= in_req.table_value;
        s1_frac_reg[0] <= in_req.coord_x[FB-1:0];
        s1_frac_reg[1] <= in_req.coord_y[FB-1:0];
        s1_frac_reg[2] <= in_req.coord_z[FB-1:0];
        s1_y_reg       <= IW'(in_req.coord_y >> FB);
        s1_z_reg       <= IW'(in_req.coord_z >> FB);
    end

    // ---------------- stage 1: level-2 reads, fade step one ----------------
    logic [IW-1:0]        a1;
    logic [IW-1:0]        b1;
    logic                 wr1;
    logic [BW-1:0]        l2a_a;
    logic [BW-1:0]        l2a_b;
    logic [BW-1:0]        l2b_a;
    logic [BW-1:0]        l2b_b;
    logic signed [QW-1:0] t1 [3];
    logic signed [QW-1:0] t2_c [3];
    logic signed [QW-1:0] m1_c [3];

    assign a1  = IW'(l1_a) + s1_y_reg;
    assign b1  = IW'(l1_b) + s1_y_reg;
    assign wr1 = s1_valid_reg && (s1_op_reg == gn3d_pkg::OP_WRITE);

    gn3d_ram #(.WIDTH(BW), .DEPTH(gn3d_pkg::TABLE_ENTRIES)) u_ram_l2a (
        .clk(clk), .we(wr1), .waddr(s1_index_reg), .wdata(s1_value_reg),
        .raddr_a(a1), .raddr_b(a1 + IW'(1)), .rdata_a(l2a_a), .rdata_b(l2a_b)
    );

    gn3d_ram #(.WIDTH(BW), .DEPTH(gn3d_pkg::TABLE_ENTRIES)) u_ram_l2b (
        .clk(clk), .we(wr1), .waddr(s1_index_reg), .wdata(s1_value_reg),
        .raddr_a(b1), .raddr_b(b1 + IW'(1)), .rdata_a(l2b_a), .rdata_b(l2b_b)
    );

    // t*t and t*(6t - 15)
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t1[i]   = signed'(QW'(s1_frac_reg[i]));
            t2_c[i] = gn3d_pkg::mulq(t1[i], t1[i]);
            m1_c[i] = gn3d_pkg::mulq(t1[i], t1[i] * QW'(6) - gn3d_pkg::FIFTEEN_Q);
        end
    end

    logic                 s2_valid_reg;
    gn3d_pkg::op_t        s2_op_reg;
    logic [IW-1:0]        s2_index_reg;
    logic [BW-1:0]        s2_value_reg;
    logic [FB-1:0]        s2_frac_reg [3];
    logic [IW-1:0]        s2_z_reg;
    logic signed [QW-1:0] s2_t2_reg [3];
    logic signed [QW-1:0] s2_m1_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_op_reg    <= s1_op_reg;
        s2_index_reg <= s1_index_reg;
        s2_value_reg <= s1_value_reg;
        s2_z_reg     <= s1_z_reg;
        s2_frac_reg  <= s1_frac_reg;
        s2_t2_reg    <= t2_c;
        s2_m1_reg    <= m1_c;
    end

    // ---------------- stage 2: level-3 reads, fade step two ----------------
    logic [IW-1:0]        aa2;
    logic [IW-1:0]        ab2;
    logic [IW-1:0]        ba2;
    logic [IW-1:0]        bb2;
    logic                 wr2;
    logic [BW-1:0]        h_aa0;
    logic [BW-1:0]        h_aa1;
    logic [BW-1:0]        h_ab0;
    logic [BW-1:0]        h_ab1;
    logic [BW-1:0]        h_ba0;
    logic [BW-1:0]        h_ba1;
    logic [BW-1:0]        h_bb0;
    logic [BW-1:0]        h_bb1;
    logic signed [QW-1:0] t_2 [3];
    logic signed [QW-1:0] t3_c [3];
    logic signed [QW-1:0] inner_c [3];

    assign aa2 = IW'(l2a_a) + s2_z_reg;
    assign ab2 = IW'(l2a_b) + s2_z_reg;
    assign ba2 = IW'(l2b_a) + s2_z_reg;
    assign bb2 = IW'(l2b_b) + s2_z_reg;
    assign wr2 = s2_valid_reg && (s2_op_reg == gn3d_pkg::OP_WRITE);

    gn3d_ram #(.WIDTH(BW), .DEPTH(gn3d_pkg::TABLE_ENTRIES)) u_ram_l3aa (
        .clk(clk), .we(wr2), .waddr(s2_index_reg), .wdata(s2_value_reg),
        .raddr_a(aa2), .raddr_b(aa2 + IW'(1)), .rdata_a(h_aa0), .rdata_b(h_aa1)
    );

    gn3d_ram #(.WIDTH(BW), .DEPTH(gn3d_pkg::TABLE_ENTRIES)) u_ram_l3ab (
        .clk(clk), .we(wr2), .waddr(s2_index_reg), .wdata(s2_value_reg),
        .raddr_a(ab2), .raddr_b(ab2 + IW'(1)), .rdata_a(h_ab0), .rdata_b(h_ab1)
    );

    gn3d_ram #(.WIDTH(BW), .DEPTH(gn3d_pkg::TABLE_ENTRIES)) u_ram_l3ba (
        .clk(clk), .we(wr2), .waddr(s2_index_reg), .wdata(s2_value_reg),
        .raddr_a(ba2), .raddr_b(ba2 + IW'(1)), .rdata_a(h_ba0), .rdata_b(h_ba1)
    );

    gn3d_ram #(.WIDTH(BW), .DEPTH(gn3d_pkg::TABLE_ENTRIES)) u_ram_l3bb (
        .clk(clk), .we(wr2), .waddr(s2_index_reg), .wdata(s2_value_reg),
        .raddr_a(bb2), .raddr_b(bb2 + IW'(1)), .rdata_a(h_bb0), .rdata_b(h_bb1)
    );

    // t^3 and t*(t*(6t - 15) + 10)
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t_2[i]     = signed'(QW'(s2_frac_reg[i]));
            t3_c[i]    = gn3d_pkg::mulq(s2_t2_reg[i], t_2[i]);
            inner_c[i] = gn3d_pkg::mulq(t_2[i], s2_m1_reg[i] + gn3d_pkg::TEN_Q);
        end
    end

    logic                 s3_valid_reg;
    logic [FB-1:0]        s3_frac_reg [3];
    logic signed [QW-1:0] s3_t3_reg [3];
    logic signed [QW-1:0] s3_inner_reg [3];

    // writes end here; only evaluates go on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg && (s2_op_reg == gn3d_pkg::OP_EVAL);
        end
    end

    always_ff @(posedge clk)
    begin
        s3_frac_reg  <= s2_frac_reg;
        s3_t3_reg    <= t3_c;
        s3_inner_reg <= inner_c;
    end

    // ---------------- stage 3: corner gradients, fade product ----------------
    logic signed [QW-1:0] f3 [3];
    logic signed [QW-1:0] g3 [3];
    logic signed [QW-1:0] grad_c [8];
    logic signed [QW-1:0] fade_c [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            f3[i]     = signed'(QW'(s3_frac_reg[i]));
            g3[i]     = f3[i] - gn3d_pkg::ONE_Q;
            fade_c[i] = gn3d_pkg::mulq(s3_t3_reg[i], s3_inner_reg[i]);
        end
        grad_c[0] = gn3d_pkg::grad(h_aa0, f3[0], f3[1], f3[2]);
        grad_c[1] = gn3d_pkg::grad(h_ba0, g3[0], f3[1], f3[2]);
        grad_c[2] = gn3d_pkg::grad(h_ab0, f3[0], g3[1], f3[2]);
        grad_c[3] = gn3d_pkg::grad(h_bb0, g3[0], g3[1], f3[2]);
        grad_c[4] = gn3d_pkg::grad(h_aa1, f3[0], f3[1], g3[2]);
        grad_c[5] = gn3d_pkg::grad(h_ba1, g3[0], f3[1], g3[2]);
        grad_c[6] = gn3d_pkg::grad(h_ab1, f3[0], g3[1], g3[2]);
        grad_c[7] = gn3d_pkg::grad(h_bb1, g3[0], g3[1], g3[2]);
    end

    logic                 s4_valid_reg;
    logic signed [QW-1:0] s4_grad_reg [8];
    logic signed [QW-1:0] s4_fade_reg [3];

    always_ff @(posedge clk)
    begin
        s4_grad_reg <= grad_c;
        s4_fade_reg <= fade_c;
    end

    // ---------------- stage 4: lerp along x ----------------
    logic signed [QW-1:0] lx_c [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            lx_c[k] = gn3d_pkg::lerp(s4_fade_reg[0], s4_grad_reg[2*k], s4_grad_reg[2*k+1]);
        end
    end

    logic                 s5_valid_reg;
    logic signed [QW-1:0] s5_lx_reg [4];
    logic signed [QW-1:0] s5_v_reg;
    logic signed [QW-1:0] s5_w_reg;

    always_ff @(posedge clk)
    begin
        s5_lx_reg <= lx_c;
        s5_v_reg  <= s4_fade_reg[1];
        s5_w_reg  <= s4_fade_reg[2];
    end

    // ---------------- stage 5: lerp along y ----------------
    logic                 s6_valid_reg;
    logic signed [QW-1:0] s6_ly_reg [2];
    logic signed [QW-1:0] s6_w_reg;

    always_ff @(posedge clk)
    begin
        s6_ly_reg[0] <= gn3d_pkg::lerp(s5_v_reg, s5_lx_reg[0], s5_lx_reg[1]);
        s6_ly_reg[1] <= gn3d_pkg::lerp(s5_v_reg, s5_lx_reg[2], s5_lx_reg[3]);
        s6_w_reg     <= s5_w_reg;
    end

    // ---------------- stage 6: lerp along z ----------------
    logic                 s7_valid_reg;
    logic signed [QW-1:0] s7_res_reg;

    always_ff @(posedge clk)
    begin
        s7_res_reg <= gn3d_pkg::lerp(s6_w_reg, s6_ly_reg[0], s6_ly_reg[1]);
    end

    // stage 7: (n + 1) / 2 to Q1.16, saturate
    logic signed [QW:0]        sum;
    logic [SW-1:0]             wide;
    logic [SW-1:0]             shifted;
    logic [gn3d_pkg::OUT_W-1:0] scaled;
    logic                      done_reg;
    logic [gn3d_pkg::OUT_W-1:0] noise_reg;

    always_comb
    begin
        sum     = (QW+1)'(s7_res_reg) + (QW+1)'(gn3d_pkg::ONE_Q);
        wide    = (SW'($unsigned(sum)) << 16) + (SW'(1) << FB);
        shifted = wide >> (FB + 1);
        if (sum <= 0)
        begin
            scaled = '0;
        end
        else if (shifted > SW'(gn3d_pkg::OUT_MAX))
        begin
            scaled = gn3d_pkg::OUT_MAX;
        end
        else
        begin
            scaled = gn3d_pkg::OUT_W'(shifted);
        end
    end

    always_ff @(posedge clk)
    begin
        noise_reg <= scaled;
    end

    // valid chain for the arithmetic stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            done_reg     <= s7_valid_reg;
        end
    end

    assign done        = done_reg;
    assign noise_value = noise_reg;

endmodule

// File: rtl/gradient_noise_3d.sv
`timescale 1ns / 1ps
// gradient_noise_3d: improved 3-D gradient noise in fixed point, top level.
// Depends on gn3d_pkg, gn3d_front, gn3d_queue, gn3d_back (and gn3d_ram).
//
// Usage:
//   A request is taken at a rising edge with start high and busy low.
//   operation = 1 writes table_value into table entry table_index and gives
//   no result; operation = 0 evaluates noise at coord_x/y/z (8.16 unsigned,
//   integer parts wrap at 256). Fill all 256 table entries before the first
//   evaluate.
//   Each evaluate gives one result: done is high for exactly one cycle with
//   noise_value = (n + 1) / 2 as Q1.16, 0..65536. The request passes the
//   front register, the queue, three table levels, fade/gradient, three lerp
//   levels and output scaling before done rises.
//   Throughput is one request per cycle; the back end drains the queue every
//   cycle, so busy stays low. Writes travel the same pipeline and update each
//   table copy in order with the reads of that copy.
//   The receiver cannot stall; results are never held.
//   Reset clears all valid state; table contents are kept and must be rewritten
//   before use if never written.
module gradient_noise_3d (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          operation,
    input  logic [gn3d_pkg::COORD_W-1:0]  coord_x,
    input  logic [gn3d_pkg::COORD_W-1:0]  coord_y,
    input  logic [gn3d_pkg::COORD_W-1:0]  coord_z,
    input  logic [gn3d_pkg::BYTE_W-1:0]   table_index,
    input  logic [gn3d_pkg::BYTE_W-1:0]   table_value,
    output logic                          busy,
    output logic                          done,
    output logic [gn3d_pkg::OUT_W-1:0]    noise_value
);

    gn3d_pkg::q_stat_t q_stat;
    gn3d_pkg::req_t    push_req;
    gn3d_pkg::req_t    head;
    logic              push;

    // accept and classify
    gn3d_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .operation(operation),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .table_index(table_index), .table_value(table_value),
        .q_stat(q_stat), .busy(busy), .push(push), .push_req(push_req)
    );

    // decoupling queue
    gn3d_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_req(push_req),
        .q_stat(q_stat), .head(head)
    );

    // noise pipeline
    gn3d_back u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(q_stat.valid), .in_req(head),
        .done(done), .noise_value(noise_value)
    );

    // an accepted evaluate yields a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == 1'(gn3d_pkg::OP_EVAL))) |-> ##10 done)
    else $error("evaluate did not produce a result on time");

    // an accepted table write yields no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == 1'(gn3d_pkg::OP_WRITE))) |-> ##10 !done)
    else $error("table write produced a result");

    // saturation keeps results in range
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (noise_value <= gn3d_pkg::OUT_MAX))
    else $error("noise_value out of range");

endmodule

// File: tb/gradient_noise_3d_tb.sv
`timescale 1ns / 1ps
// gradient_noise_3d_tb: self-checking bench for the 3-D gradient noise block.
// Depends on gn3d_pkg and gradient_noise_3d; fills the table, then checks evaluates.
module gradient_noise_3d_tb;
    import gn3d_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                operation;
    logic [COORD_W-1:0]  coord_x;
    logic [COORD_W-1:0]  coord_y;
    logic [COORD_W-1:0]  coord_z;
    logic [BYTE_W-1:0]   table_index;
    logic [BYTE_W-1:0]   table_value;
    logic                busy;
    logic                done;
    logic [OUT_W-1:0]    noise_value;

    gradient_noise_3d dut (
        .clk(clk), .rst_n(rst_n), .start(start), .operation(operation),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .table_index(table_index), .table_value(table_value),
        .busy(busy), .done(done), .noise_value(noise_value)
    );

    // Clock, 20 ns period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    typedef logic signed [63:0] q64_t;

    req_t              pending_reqs[$];
    logic [OUT_W-1:0]  expected_noise[$];
    logic [7:0]        perm_shadow[256];
    int                mismatches;
    int                evals_checked;
    int                writes_sent;
    int                cycle_count;
    int                idle_left;
    bit                stim_done;

    // Rounded signed product, halves away from zero
    function automatic q64_t qmul(q64_t a, q64_t b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] r;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        r  = (ma * mb + 64'd32768) >> 16;
        return ((a < 0) != (b < 0)) ? -q64_t'(r) : q64_t'(r);
    endfunction

    function automatic q64_t fade_curve(q64_t t);
        q64_t t3;
        q64_t inner;
        t3    = qmul(qmul(t, t), t);
        inner = qmul(t, qmul(t, 6 * t - 15 * 65536) + 10 * 65536);
        return qmul(t3, inner);
    endfunction

    function automatic q64_t blend(q64_t t, q64_t a, q64_t b);
        return a + qmul(t, b - a);
    endfunction

    function automatic q64_t corner_dot(int hash, q64_t x, q64_t y, q64_t z);
        logic [3:0] h;
        q64_t       u;
        q64_t       v;
        h = hash[3:0];
        u = h < 4'd8 ? x : y;
        v = h < 4'd4 ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic int hash_of(int n);
        return int'(perm_shadow[n & 255]);
    endfunction

    // Expected noise for one evaluate request
    function automatic logic [OUT_W-1:0] noise_at(req_t r);
        int   xi, yi, zi, a, b, aa, ab, ba, bb;
        q64_t fx, fy, fz, gx, gy, gz, u, v, w, res, sum;
        logic [63:0] scaled;
        xi = int'(r.coord_x[23:16]);
        yi = int'(r.coord_y[23:16]);
        zi = int'(r.coord_z[23:16]);
        fx = q64_t'(r.coord_x[15:0]);
        fy = q64_t'(r.coord_y[15:0]);
        fz = q64_t'(r.coord_z[15:0]);
        gx = fx - 65536; gy = fy - 65536; gz = fz - 65536;
        u = fade_curve(fx); v = fade_curve(fy); w = fade_curve(fz);
        a  = hash_of(xi) + yi;
        aa = hash_of(a) + zi;
        ab = hash_of(a + 1) + zi;
        b  = hash_of(xi + 1) + yi;
        ba = hash_of(b) + zi;
        bb = hash_of(b + 1) + zi;
        res = blend(w,
            blend(v,
                blend(u, corner_dot(hash_of(aa), fx, fy, fz),
                         corner_dot(hash_of(ba), gx, fy, fz)),
                blend(u, corner_dot(hash_of(ab), fx, gy, fz),
                         corner_dot(hash_of(bb), gx, gy, fz))),
            blend(v,
                blend(u, corner_dot(hash_of(aa + 1), fx, fy, gz),
                         corner_dot(hash_of(ba + 1), gx, fy, gz)),
                blend(u, corner_dot(hash_of(ab + 1), fx, gy, gz),
                         corner_dot(hash_of(bb + 1), gx, gy, gz))));
        sum = res + 65536;
        if (sum <= 0)
            scaled = 0;
        else
        begin
            scaled = ((64'(sum) << 16) + 64'd65536) >> 17;
            if (scaled > 65536)
                scaled = 65536;
        end
        return scaled[OUT_W-1:0];
    endfunction

    function automatic req_t eval_req(logic [23:0] x, logic [23:0] y, logic [23:0] z);
        req_t r;
        r = '0;
        r.op = OP_EVAL;
        r.coord_x = x; r.coord_y = y; r.coord_z = z;
        r.table_index = 8'($urandom); r.table_value = 8'($urandom);
        return r;
    endfunction

    function automatic req_t write_req(logic [7:0] idx, logic [7:0] val);
        req_t r;
        r = '0;
        r.op = OP_WRITE;
        r.table_index = idx; r.table_value = val;
        r.coord_x = 24'($urandom); r.coord_y = 24'($urandom); r.coord_z = 24'($urandom);
        return r;
    endfunction

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return {8'($urandom), 16'h0000};
            3: return {8'($urandom), 16'hFFFF};
            default: return 24'($urandom);
        endcase
    endfunction

    // Stimulus: shuffled table fill, directed evaluates and table-edge writes, then a random mix
    initial
    begin
        logic [7:0] shuf[256];
        logic [7:0] tmp;
        int         j;
        stim_done   = 1'b0;
        for (int i = 0; i < 256; i++)
            shuf[i] = 8'(i);
        for (int i = 255; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = shuf[i]; shuf[i] = shuf[j]; shuf[j] = tmp;
        end
        for (int i = 0; i < 256; i++)
            pending_reqs.push_back(write_req(8'(i), shuf[i]));
        // extremes: zero, all ones, lattice points, fraction edges, wrap
        pending_reqs.push_back(eval_req(24'h000000, 24'h000000, 24'h000000));
        pending_reqs.push_back(eval_req(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        pending_reqs.push_back(eval_req(24'h010000, 24'h020000, 24'h030000));
        pending_reqs.push_back(eval_req(24'h008000, 24'h008000, 24'h008000));
        pending_reqs.push_back(eval_req(24'hFF0000, 24'h00FFFF, 24'hFF8000));
        pending_reqs.push_back(eval_req(24'h00FFFF, 24'hFFFFFF, 24'h000001));
        pending_reqs.push_back(eval_req(24'hFF7FFF, 24'h7F8001, 24'h80FFFF));
        pending_reqs.push_back(eval_req(24'hAAAAAA, 24'h555555, 24'hAAAAAA));
        pending_reqs.push_back(eval_req(24'h555555, 24'hAAAAAA, 24'h555555));
        // table edges: entry 0 and 255 with extreme bytes
        pending_reqs.push_back(write_req(8'h00, 8'hFF));
        pending_reqs.push_back(write_req(8'hFF, 8'h00));
        pending_reqs.push_back(eval_req(24'hFF4000, 24'h00C000, 24'hFF2000));
        // random mix, mostly evaluates, some rewrites interleaved
        for (int i = 0; i < 620; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                pending_reqs.push_back(write_req(8'($urandom), 8'($urandom)));
            else
                pending_reqs.push_back(eval_req(rand_coord(), rand_coord(), rand_coord()));
        end
        stim_done = 1'b1;
    end

    // Driver: one request per accepted edge, idle bursts except for the last 100
    always @(posedge clk or negedge rst_n)
    begin
        req_t r;
        if (!rst_n)
        begin
            start       <= 1'b0;
            operation   <= OP_EVAL;
            coord_x     <= '0;
            coord_y     <= '0;
            coord_z     <= '0;
            table_index <= '0;
            table_value <= '0;
            idle_left   <= 0;
        end
        else if (!(start && busy))
        begin
            // a request launched last edge was taken now unless busy
            if (idle_left > 0)
            begin
                start     <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                r = pending_reqs.pop_front();
                if (r.op == OP_WRITE)
                begin
                    perm_shadow[r.table_index] = r.table_value;
                    writes_sent++;
                end
                else
                    expected_noise.push_back(noise_at(r));
                start       <= 1'b1;
                operation   <= r.op;
                coord_x     <= r.coord_x;
                coord_y     <= r.coord_y;
                coord_z     <= r.coord_z;
                table_index <= r.table_index;
                table_value <= r.table_value;
                if (pending_reqs.size() > 100 && $urandom_range(0, 5) == 0)
                    idle_left <= $urandom_range(1, 5);
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        logic [OUT_W-1:0] exp_v;
        if (rst_n && done)
        begin
            if (expected_noise.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result noise_value=%0d", noise_value);
            end
            else
            begin
                exp_v = expected_noise.pop_front();
                evals_checked++;
                if (noise_value !== exp_v)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: noise_value expected %0d got %0d", exp_v,
                                 noise_value);
                end
            end
        end
    end

    // Reset, completion wait and final verdict
    initial
    begin
        mismatches    = 0;
        evals_checked = 0;
        writes_sent   = 0;
        cycle_count   = 0;
        rst_n         = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (!(stim_done && pending_reqs.size() == 0 && !start
                 && expected_noise.size() == 0) && cycle_count < 200000)
        begin
            @(posedge clk);
            cycle_count++;
        end
        if (cycle_count >= 200000)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            repeat (20) @(posedge clk);
            if (expected_noise.size() != 0)
                mismatches++;
            $display("Covered %0d table writes and %0d checked noise evaluations,",
                     writes_sent, evals_checked);
            $display("including lattice, wrap and fraction-edge coordinates; %0d mismatches.",
                     mismatches);
            if (mismatches == 0)
                $display("Test completed successfully");
            else
                $display("Test completed with failures");
            $finish;
        end
    end

endmodule

// File: sim.f
rtl/gn3d_pkg.sv
rtl/gn3d_ram.sv
rtl/gn3d_front.sv
rtl/gn3d_queue.sv
rtl/gn3d_back.sv
rtl/gradient_noise_3d.sv
tb/gradient_noise_3d_tb.sv
